[rtl/core/gcq_pkg.sv]
// shared types and constants for the grouped class fifo queue
package gcq_pkg;

  localparam int CLASS_COUNT     = 4;
  localparam int PER_CLASS_DEPTH = 1024;

  localparam int CLS_W   = 2;
  localparam int TAG_W   = 16;
  localparam int PTR_W   = $clog2(PER_CLASS_DEPTH);
  localparam int OCC_W   = $clog2(PER_CLASS_DEPTH + 1);
  localparam int GRP_W   = $clog2(CLASS_COUNT + 1);
  localparam int STORE_DEPTH = CLASS_COUNT * PER_CLASS_DEPTH;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0]  wdata;
  } ram_cmd_t;

  typedef struct packed {
    status_e          status;
    logic [CLS_W-1:0] cls;
    logic             deq;
  } resp_t;

endpackage

[rtl/core/gcq_ram.sv]
// generic single port ram with registered read
module gcq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gcq_ctrl.sv]
// class pointers, occupancy and group order update for the grouped class queue
module gcq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  gcq_pkg::op_e              op_i,
  input  logic [gcq_pkg::CLS_W-1:0] cls_i,
  input  logic [gcq_pkg::TAG_W-1:0] tag_i,
  output gcq_pkg::ram_cmd_t         ram_cmd_o,
  output gcq_pkg::resp_t            resp_o
);

  logic [gcq_pkg::PTR_W-1:0] head_q  [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::PTR_W-1:0] head_d  [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::PTR_W-1:0] tail_q  [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::PTR_W-1:0] tail_d  [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::OCC_W-1:0] occ_q   [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::OCC_W-1:0] occ_d   [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::CLS_W-1:0] order_q [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::CLS_W-1:0] order_d [gcq_pkg::CLASS_COUNT];
  logic [gcq_pkg::GRP_W-1:0] total_q;
  logic [gcq_pkg::GRP_W-1:0] total_d;
  logic [gcq_pkg::CLS_W-1:0] front;
  logic                      cls_ok;

  function automatic logic [gcq_pkg::PTR_W-1:0] next_slot(
    input logic [gcq_pkg::PTR_W-1:0] p
  );
    return (p == gcq_pkg::PTR_W'(gcq_pkg::PER_CLASS_DEPTH - 1)) ?
           '0 : p + gcq_pkg::PTR_W'(1);
  endfunction

  function automatic logic [gcq_pkg::ADDR_W-1:0] slot_addr(
    input logic [gcq_pkg::CLS_W-1:0] c,
    input logic [gcq_pkg::PTR_W-1:0] p
  );
    return gcq_pkg::ADDR_W'(c) * gcq_pkg::ADDR_W'(gcq_pkg::PER_CLASS_DEPTH) +
           gcq_pkg::ADDR_W'(p);
  endfunction

  assign front  = order_q[0];
  assign cls_ok = 32'(cls_i) < 32'(gcq_pkg::CLASS_COUNT);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    occ_d     = occ_q;
    order_d   = order_q;
    total_d   = total_q;
    ram_cmd_o = '0;
    resp_o    = '{status: gcq_pkg::ST_OK, cls: '0, deq: 1'b0};
    if (fire_i) begin
      if (op_i == gcq_pkg::OP_ENQ) begin
        if (!cls_ok || occ_q[cls_i] == gcq_pkg::OCC_W'(gcq_pkg::PER_CLASS_DEPTH)) begin
          resp_o.status = gcq_pkg::ST_FULL;
        end else begin
          ram_cmd_o.we    = 1'b1;
          ram_cmd_o.addr  = slot_addr(cls_i, tail_q[cls_i]);
          ram_cmd_o.wdata = tag_i;
          tail_d[cls_i]   = next_slot(tail_q[cls_i]);
          if (occ_q[cls_i] == '0 &&
              total_q < gcq_pkg::GRP_W'(gcq_pkg::CLASS_COUNT)) begin
            order_d[total_q[gcq_pkg::CLS_W-1:0]] = cls_i;
            total_d = total_q + gcq_pkg::GRP_W'(1);
          end
          occ_d[cls_i] = occ_q[cls_i] + gcq_pkg::OCC_W'(1);
        end
      end else begin
        if (total_q == '0) begin
          resp_o.status = gcq_pkg::ST_EMPTY;
        end else begin
          ram_cmd_o.re   = 1'b1;
          ram_cmd_o.addr = slot_addr(front, head_q[front]);
          head_d[front]  = next_slot(head_q[front]);
          resp_o.cls     = front;
          resp_o.deq     = 1'b1;
          if (occ_q[front] != '0) begin
            occ_d[front] = occ_q[front] - gcq_pkg::OCC_W'(1);
          end
          if (occ_q[front] <= gcq_pkg::OCC_W'(1)) begin
            for (int i = 0; i < gcq_pkg::CLASS_COUNT - 1; i++) begin
              if (gcq_pkg::GRP_W'(i + 1) < total_q) begin
                order_d[i] = order_q[i + 1];
              end
            end
            total_d = total_q - gcq_pkg::GRP_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gcq_pkg::CLASS_COUNT; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    order_q <= order_d;
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= gcq_pkg::GRP_W'(gcq_pkg::CLASS_COUNT))
    else $error("open group count beyond class count");

  a_front_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != '0 |-> occ_q[front] != '0)
    else $error("front group has no entries");

  a_empty_no_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == '0 |-> occ_q[0] == '0 && occ_q[1] == '0 && occ_q[2] == '0 &&
    occ_q[3] == '0)
    else $error("entries held with no open group");
`endif

endmodule

[rtl/core/grouped_class_fifo_queue_unit.sv]
// grouped class fifo queue top level: stream ports, tag store and result register
//
// channel  | dir | tdata (low bit up)                 | tuser
// s_axis   | in  | class_id[1:0] tag[17:2] zero[23:18] | opcode
// m_axis   | out | out_class[1:0] out_tag[17:2] zero  | status[1:0]
//
// one item per cycle unless stalled; the result appears in the cycle after the
// transfer, the tag read from the store lands in the ram's read register with it
// a stalled result holds its register and the ram read register
// reset clears pointers, occupancy, group count and output valid
// the tag store has no reset, only written entries are read
module grouped_class_fifo_queue_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gcq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // class_id, tag
  input  logic                           s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gcq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // out_class, out_tag
  output logic [1:0]                     m_axis_tuser   // status
);

  logic                      fire;
  logic                      valid_q;
  gcq_pkg::resp_t            resp_q;
  gcq_pkg::resp_t            resp;
  gcq_pkg::ram_cmd_t         ram_cmd;
  logic [gcq_pkg::TAG_W-1:0] rdata;
  logic [gcq_pkg::TAG_W-1:0] out_tag;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  gcq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .op_i      (gcq_pkg::op_e'(s_axis_tuser)),
    .cls_i     (s_axis_tdata[gcq_pkg::CLS_W-1:0]),
    .tag_i     (s_axis_tdata[gcq_pkg::CLS_W +: gcq_pkg::TAG_W]),
    .ram_cmd_o (ram_cmd),
    .resp_o    (resp)
  );

  gcq_ram #(
    .WIDTH (gcq_pkg::TAG_W),
    .DEPTH (gcq_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_cmd.we),
    .re_i    (ram_cmd.re),
    .addr_i  (ram_cmd.addr),
    .wdata_i (ram_cmd.wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      resp_q <= resp;
    end
  end

  assign out_tag       = resp_q.deq ? rdata : '0;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = resp_q.status;
  assign m_axis_tdata  = {
    (gcq_pkg::OUT_DATA_W - gcq_pkg::TAG_W - gcq_pkg::CLS_W)'(0), out_tag, resp_q.cls
  };

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && resp_q.status != gcq_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("refused item carries class or tag");

  a_deq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && resp_q.deq |-> resp_q.status == gcq_pkg::ST_OK)
    else $error("dequeue result with error status");
`endif

endmodule

[tb/tb_top.sv]
// testbench for grouped_class_fifo_queue_unit: predicts each result and checks every transfer
module tb_top;
  import gcq_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [CLS_W-1:0] cls;
    logic [TAG_W-1:0] tag;
  } queue_result_t;

  class team_queue_tracker;
    logic [TAG_W-1:0] tag_mem [CLASS_COUNT][PER_CLASS_DEPTH];
    logic [PTR_W-1:0] head [CLASS_COUNT];
    logic [PTR_W-1:0] tail [CLASS_COUNT];
    logic [OCC_W-1:0] fill [CLASS_COUNT];
    logic [CLS_W-1:0] order [CLASS_COUNT];
    logic [GRP_W-1:0] open_groups;
    queue_result_t    awaited [$];
    int unsigned      mismatches, checked, enq_count, deq_count, empty_hits, full_hits;

    function new();
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head[i] = '0;
        tail[i] = '0;
        fill[i] = '0;
        order[i] = '0;
      end
      open_groups = '0;
      mismatches = 0;
      checked = 0;
      enq_count = 0;
      deq_count = 0;
      empty_hits = 0;
      full_hits = 0;
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // one accepted request, one expected result
    function void note_request(op_e op, logic [CLS_W-1:0] cls, logic [TAG_W-1:0] tag);
      queue_result_t r;
      logic [CLS_W-1:0] c;
      r.status = ST_OK;
      r.cls = '0;
      r.tag = '0;
      if (op == OP_ENQ) begin
        enq_count++;
        if (fill[cls] >= PER_CLASS_DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          tag_mem[cls][tail[cls]] = tag;
          tail[cls] = (tail[cls] == PER_CLASS_DEPTH - 1) ? '0 : tail[cls] + 1'b1;
          if (fill[cls] == 0 && open_groups < CLASS_COUNT) begin
            order[open_groups] = cls;
            open_groups++;
          end
          fill[cls]++;
        end
      end else begin
        deq_count++;
        if (open_groups == 0) begin
          r.status = ST_EMPTY;
          empty_hits++;
        end else begin
          c = order[0];
          r.cls = c;
          r.tag = tag_mem[c][head[c]];
          head[c] = (head[c] == PER_CLASS_DEPTH - 1) ? '0 : head[c] + 1'b1;
          if (fill[c] > 0) fill[c]--;
          if (fill[c] == 0) begin
            for (int k = 0; k + 1 < open_groups; k++) order[k] = order[k + 1];
            open_groups--;
          end
        end
      end
      awaited = {awaited, r};
    endfunction

    function void check_response(logic [1:0] st, logic [CLS_W-1:0] cls,
                                 logic [TAG_W-1:0] tag);
      queue_result_t e;
      if (awaited.size() == 0) begin
        log_mismatch($sformatf("unexpected result status %0d class %0d tag %h",
                               st, cls, tag));
      end else begin
        e = awaited.pop_front();
        checked++;
        if (e.status !== st || e.cls !== cls || e.tag !== tag) begin
          log_mismatch($sformatf(
            "result %0d: expected status %0d class %0d tag %h, got status %0d class %0d tag %h",
            checked, e.status, e.cls, e.tag, st, cls, tag));
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // class_id[1:0], tag[17:2], zero
  logic                  s_axis_tuser;   // opcode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // out_class[1:0], out_tag[17:2], zero
  logic [1:0]            m_axis_tuser;   // status

  team_queue_tracker tracker;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;

  always #5 clk_i = ~clk_i;

  grouped_class_fifo_queue_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // sampled at the falling edge, so the values seen are those of the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      tracker.check_response(m_axis_tuser, m_axis_tdata[CLS_W-1:0],
                             m_axis_tdata[CLS_W+TAG_W-1:CLS_W]);
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(op_e op, logic [CLS_W-1:0] cls, logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - CLS_W - TAG_W){1'b0}}, tag, cls};
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    tracker.note_request(op, cls, tag);
  endtask

  task automatic put_tag(logic [CLS_W-1:0] cls, logic [TAG_W-1:0] tag);
    push_item(OP_ENQ, cls, tag);
  endtask

  task automatic take_front();
    push_item(OP_DEQ, CLS_W'($urandom_range(CLASS_COUNT - 1)), TAG_W'($urandom));
  endtask

  initial begin
    int unsigned n;
    int unsigned seg;
    int unsigned enq_pct;
    int unsigned guard;
    tracker = new();
    send_gap_pct   = 13;
    recv_stall_pct = 50;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_ENQ;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, group opening order, join of an open group, reopen after drain
    take_front();
    put_tag(2'd0, 16'h0000);
    put_tag(2'd3, 16'hffff);
    put_tag(2'd1, 16'h5555);
    put_tag(2'd2, 16'haaaa);
    put_tag(2'd0, 16'h1234);
    put_tag(2'd3, 16'h0001);
    repeat (7) take_front();
    put_tag(2'd2, 16'h00ff);
    take_front();
    put_tag(2'd2, 16'hff00);
    put_tag(2'd1, 16'h8001);
    repeat (3) take_front();

    n = 0;
    while (n < 1000) begin
      seg = $urandom_range(10, 60);
      enq_pct = 25 * $urandom_range(1, 3);
      repeat (seg) begin
        if (n == 350) begin
          send_gap_pct   = 50;
          recv_stall_pct = 13;
        end else if (n == 700) begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        if ($urandom_range(99) < enq_pct)
          put_tag(CLS_W'($urandom_range(CLASS_COUNT - 1)), TAG_W'($urandom));
        else
          take_front();
        n++;
      end
    end

    // drain the whole queue, then dequeue on empty
    while (tracker.open_groups != 0) take_front();
    repeat (2) take_front();
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (tracker.awaited.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (tracker.awaited.size() != 0) begin
      $display("%0d expected results never arrived", tracker.awaited.size());
      tracker.mismatches += tracker.awaited.size();
    end
    $display("covered %0d enqueues (%0d into a full class) and %0d dequeues (%0d on empty)",
             tracker.enq_count, tracker.full_hits, tracker.deq_count, tracker.empty_hits);
    $display("%0d results checked, %0d mismatches", tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
